// ----- rtl/core/pbu_pkg.sv -----
// ----------------------------------------------------------------------------
// pbu_pkg: shared types and constants of the pixel blend unit
// Mode codes, configuration register indexes, blend rounding constants and the
// stage-enable bundle passed from pipeline control to the channel lanes.
// ----------------------------------------------------------------------------
package pbu_pkg;

	typedef enum logic [2:0] {
		MODE_ADD      = 3'd0,
		MODE_SUB      = 3'd1,
		MODE_SCALE    = 3'd2,
		MODE_MULTIPLY = 3'd3,
		MODE_SCREEN   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CFG_OFFSET = 2'd0,
		CFG_SCALE  = 2'd1,
		CFG_MASK   = 2'd2
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0]  OFFSET_RST = 8'd0;
	localparam logic [15:0] SCALE_RST  = 16'd256;
	localparam logic [2:0]  MASK_RST   = 3'b111;

	// Blend divisor is 255 * 256; half of it gives round-half-up.
	localparam logic [32:0] BLEND_HALF = 33'd32640;
	// 256 * 65280: a multiply sum at or above this saturates to 255.
	localparam logic [32:0] BLEND_CLIP = 33'd16711680;
	// 255 * 65280 + 32640: screen numerator before the product is taken off.
	localparam logic [32:0] SCREEN_TOP = 33'd16679040;

	typedef struct packed {
		logic [7:0]  offset_amount;
		logic [15:0] scale_factor;
		logic [2:0]  channel_mask;
	} cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

// ----- rtl/core/pbu_if.sv -----
// ----------------------------------------------------------------------------
// pbu_if: channel interfaces of the pixel blend unit
// Pixel request channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface pbu_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] first_blue;
	logic [7:0] first_green;
	logic [7:0] first_red;
	logic [7:0] second_blue;
	logic [7:0] second_green;
	logic [7:0] second_red;

	modport source (
		output valid, mode, first_blue, first_green, first_red,
		       second_blue, second_green, second_red,
		input  ready
	);
	modport sink (
		input  valid, mode, first_blue, first_green, first_red,
		       second_blue, second_green, second_red,
		output ready
	);
endinterface

interface pbu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic       clipped;

	modport source (
		output valid, out_blue, out_green, out_red, clipped,
		input  ready
	);
	modport sink (
		input  valid, out_blue, out_green, out_red, clipped,
		output ready
	);
endinterface

interface pbu_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] wdata;

	modport source (
		output valid, index, wdata,
		input  ready
	);
	modport sink (
		input  valid, index, wdata,
		output ready
	);
endinterface

// ----- rtl/core/pixel_blend_unit_top.sv -----
// ----------------------------------------------------------------------------
// pixel_blend_unit_top: per-pixel BGR arithmetic and blend unit
// Offset add/subtract, Q8.8 scale, multiply and screen blend on a pair of
// 8-bit BGR pixels; one result pixel with a saturation flag per request.
// ----------------------------------------------------------------------------
//
//   channel   modport  payload                                   use
//   -------   -------  ----------------------------------------  -------------
//   pix_in    sink     mode, first_{blue,green,red},             pixel request
//                      second_{blue,green,red}
//   pix_out   source   out_{blue,green,red}, clipped             result
//   cfg       sink     index, wdata                              register write
//
// Four pipeline stages, stage 1 to stage 4, each registered, lie between pix_in
// and pix_out; one request enters per clock when pix_out takes results.
// The stage-2 16x16 gain product and the constant divide by 65280 (reciprocal
// estimate, then one correction step) set the stage split.
// Each stage loads when empty or when the stage after it moves, so bubbles
// close up and a stall on pix_out holds results without loss or repeat.
// arst_n clears the valid bits and restores the registers (offset 0, gain
// 1.0, all channels enabled); cfg is always ready.
// ----------------------------------------------------------------------------
module pixel_blend_unit_top
	import pbu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pbu_in_if.sink    pix_in,
	pbu_out_if.source pix_out,
	pbu_cfg_if.sink   cfg
);

	cfg_t     cfg_val;
	pipe_en_t en;
	mode_t    mode_in;
	logic     clip_blue, clip_green, clip_red;

	// Take writes at any time; only idle periods see them by contract.
	assign cfg.ready = 1'b1;

	pbu_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid && cfg.ready),
		.wr_idx  (cfg.index),
		.wr_data (cfg.wdata),
		.cfg     (cfg_val)
	);

	// Valid bits and per-stage load enables.
	pbu_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.en        (en)
	);

	// Unused codes pass through the lanes as inactive channels.
	assign mode_in = mode_t'(pix_in.mode);

	// One lane per color; the mask bit only matters for add, subtract and scale.
	pbu_lane u_blue (
		.clk      (clk),
		.en       (en),
		.cfg      (cfg_val),
		.mode     (mode_in),
		.mask_bit (cfg_val.channel_mask[0]),
		.a        (pix_in.first_blue),
		.b        (pix_in.second_blue),
		.res      (pix_out.out_blue),
		.clip     (clip_blue)
	);

	pbu_lane u_green (
		.clk      (clk),
		.en       (en),
		.cfg      (cfg_val),
		.mode     (mode_in),
		.mask_bit (cfg_val.channel_mask[1]),
		.a        (pix_in.first_green),
		.b        (pix_in.second_green),
		.res      (pix_out.out_green),
		.clip     (clip_green)
	);

	pbu_lane u_red (
		.clk      (clk),
		.en       (en),
		.cfg      (cfg_val),
		.mode     (mode_in),
		.mask_bit (cfg_val.channel_mask[2]),
		.a        (pix_in.first_red),
		.b        (pix_in.second_red),
		.res      (pix_out.out_red),
		.clip     (clip_red)
	);

	// Flag the pixel if any channel saturated.
	assign pix_out.clipped = clip_blue | clip_green | clip_red;

endmodule

// ----- rtl/core/pbu_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pbu_cfg_regs: configuration registers
// Offset, Q8.8 gain and channel mask; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module pbu_cfg_regs
	import pbu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_idx,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	logic [7:0]  offset_q;
	logic [15:0] scale_q;
	logic [2:0]  mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
			scale_q  <= SCALE_RST;
			mask_q   <= MASK_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_idx))
				CFG_OFFSET: offset_q <= wr_data[7:0];
				CFG_SCALE:  scale_q  <= wr_data[15:0];
				CFG_MASK:   mask_q   <= wr_data[2:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	assign cfg.offset_amount = offset_q;
	assign cfg.scale_factor  = scale_q;
	assign cfg.channel_mask  = mask_q;

endmodule

// ----- rtl/core/pbu_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbu_pipe_ctrl: pipeline valid bits and stage enables
// Four stages; a stage loads when it is empty or its successor loads, so
// bubbles collapse and a stall holds the last stage and full stages behind it.
// ----------------------------------------------------------------------------
module pbu_pipe_ctrl
	import pbu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output pipe_en_t en
);

	logic v_s1, v_s2, v_s3, v_s4;

	always_comb begin
		en.s4 = !v_s4 || out_ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s4;

endmodule

// ----- rtl/core/pbu_lane.sv -----
// ----------------------------------------------------------------------------
// pbu_lane: one color channel datapath
// Stage 1 offsets and first products, stage 2 gain product and scale
// rounding, stage 3 blend numerator and reciprocal estimate, stage 4
// quotient correction and result select.
// ----------------------------------------------------------------------------
module pbu_lane
	import pbu_pkg::*;
(
	input  logic       clk,
	input  pipe_en_t   en,
	input  cfg_t       cfg,
	input  mode_t      mode,
	input  logic       mask_bit,
	input  logic [7:0] a,
	input  logic [7:0] b,
	output logic [7:0] res,
	output logic       clip
);

	// stage 1
	mode_t       mode_s1;
	logic        act_s1;
	logic [7:0]  a_s1;
	logic [7:0]  simple_s1;
	logic        sclip_s1;
	logic [15:0] xy_s1;
	logic [23:0] as_s1;
	// stage 2
	mode_t       mode_s2;
	logic        act_s2;
	logic [7:0]  a_s2;
	logic [7:0]  simple_s2;
	logic        sclip_s2;
	logic [31:0] p_s2;
	// stage 3
	mode_t       mode_s3;
	logic        act_s3;
	logic [7:0]  a_s3;
	logic [7:0]  simple_s3;
	logic        sclip_s3;
	logic        bclip_s3;
	logic [15:0] y_s3;
	logic [7:0]  q0_s3;
	// stage 4
	logic [7:0]  res_s4;
	logic        clip_s4;

	logic        act_c;
	logic [8:0]  sum_c;
	logic [7:0]  x_c, w_c;
	logic [7:0]  simple1_c;
	logic        sclip1_c;
	logic [24:0] scl_c;
	logic [7:0]  simple2_c;
	logic        sclip2_c;
	logic [32:0] d_c;
	logic        bclip_c;
	logic [23:0] y257_c;
	logic [16:0] rem_c;
	logic [7:0]  q_c;
	logic [7:0]  res_c;
	logic        clip_c;

	// stage 1: add/subtract, operand select for the blends
	always_comb begin
		sum_c     = {1'b0, a} + {1'b0, cfg.offset_amount};
		simple1_c = a;
		sclip1_c  = 1'b0;
		act_c     = 1'b0;
		x_c       = a;
		w_c       = b;
		unique case (mode)
			MODE_ADD: begin
				act_c     = mask_bit;
				sclip1_c  = sum_c[8];
				simple1_c = sum_c[8] ? 8'hFF : sum_c[7:0];
			end
			MODE_SUB: begin
				act_c     = mask_bit;
				sclip1_c  = a < cfg.offset_amount;
				simple1_c = sclip1_c ? 8'h00 : a - cfg.offset_amount;
			end
			MODE_SCALE:    act_c = mask_bit;
			MODE_MULTIPLY: act_c = 1'b1;
			MODE_SCREEN: begin
				act_c = 1'b1;
				x_c   = ~a;
				w_c   = ~b;
			end
			default: act_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mode_s1   <= mode;
			act_s1    <= act_c;
			a_s1      <= a;
			simple_s1 <= simple1_c;
			sclip_s1  <= sclip1_c;
			xy_s1     <= 16'(x_c) * 16'(w_c);
			as_s1     <= 24'(a) * 24'(cfg.scale_factor);
		end
	end

	// stage 2: round and clamp the scale result, take the gain product
	always_comb begin
		scl_c     = {1'b0, as_s1} + 25'd128;
		simple2_c = simple_s1;
		sclip2_c  = sclip_s1;
		if (mode_s1 == MODE_SCALE) begin
			sclip2_c  = |scl_c[24:16];
			simple2_c = sclip2_c ? 8'hFF : scl_c[15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mode_s2   <= mode_s1;
			act_s2    <= act_s1;
			a_s2      <= a_s1;
			simple_s2 <= simple2_c;
			sclip_s2  <= sclip2_c;
			p_s2      <= 32'(xy_s1) * 32'(cfg.scale_factor);
		end
	end

	// stage 3: rounded numerator, saturation test, quotient estimate by 257/65536
	always_comb begin
		if (mode_s2 == MODE_SCREEN) begin
			bclip_c = {1'b0, p_s2} > SCREEN_TOP;
			d_c     = SCREEN_TOP - {1'b0, p_s2};
		end else begin
			d_c     = {1'b0, p_s2} + BLEND_HALF;
			bclip_c = d_c >= BLEND_CLIP;
		end
		y257_c = {d_c[23:8], 8'h00} + {8'h00, d_c[23:8]};
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			mode_s3   <= mode_s2;
			act_s3    <= act_s2;
			a_s3      <= a_s2;
			simple_s3 <= simple_s2;
			sclip_s3  <= sclip_s2;
			bclip_s3  <= bclip_c;
			y_s3      <= d_c[23:8];
			q0_s3     <= y257_c[23:16];
		end
	end

	// stage 4: correct the estimate by one, pick the result
	always_comb begin
		rem_c = {1'b0, y_s3} - ({1'b0, q0_s3, 8'h00} - {9'h000, q0_s3});
		q_c   = (rem_c >= 17'd255) ? q0_s3 + 8'd1 : q0_s3;
		res_c = a_s3;
		clip_c = 1'b0;
		if (act_s3) begin
			unique case (mode_s3)
				MODE_MULTIPLY: begin
					res_c  = bclip_s3 ? 8'hFF : q_c;
					clip_c = bclip_s3;
				end
				MODE_SCREEN: begin
					res_c  = bclip_s3 ? 8'h00 : q_c;
					clip_c = bclip_s3;
				end
				default: begin
					res_c  = simple_s3;
					clip_c = sclip_s3;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_s4  <= res_c;
			clip_s4 <= clip_c;
		end
	end

	assign res  = res_s4;
	assign clip = clip_s4;

endmodule

// ----- rtl/core/pbu_checker.sv -----
// ----------------------------------------------------------------------------
// pbu_checker: port-level checks of the pixel blend unit
// Result hold under stall and the ready chain seen from the ports.
// ----------------------------------------------------------------------------
module pbu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_blue,
	input logic [7:0] out_green,
	input logic [7:0] out_red,
	input logic       clipped
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(out_blue) && $stable(out_green) && $stable(out_red) && $stable(clipped))
		else $error("result changed while stalled");

	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("request blocked while result side is ready");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("request blocked with no result waiting");

endmodule

bind pixel_blend_unit_top pbu_checker u_pbu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_blue  (pix_out.out_blue),
	.out_green (pix_out.out_green),
	.out_red   (pix_out.out_red),
	.clipped   (pix_out.clipped)
);

// ----- verif/pixel_blend_unit_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_blend_unit_top_tb: self-checking bench for the pixel blend unit
// Feeds pixel requests through the input channel under varying register
// settings and idle patterns. Each accepted request is run through a local
// integer model of the five modes with saturation and channel masking, and
// every result pixel is checked field by field, in order, against it.
// ----------------------------------------------------------------------------
module pixel_blend_unit_top_tb
	import pbu_pkg::*;
;

	// Mode codes with no operation behind them: the first pixel passes through.
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
	// Index with no register behind it: a write there must change nothing.
	localparam logic [1:0] CFG_NONE = 2'd3;

	// Blend divisor 255 * 256, its half for round-half-up, screen numerator.
	localparam longint unsigned BLEND_DIV = 64'd65280;
	localparam longint unsigned BLEND_RND = 64'd32640;
	localparam longint unsigned SCREEN_NUM = 64'd255 * 64'd65280 + 64'd32640;

	localparam int PHASE_COUNT = 12;
	localparam int PHASE_REQS = 156;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] first_blue;
		logic [7:0] first_green;
		logic [7:0] first_red;
		logic [7:0] second_blue;
		logic [7:0] second_green;
		logic [7:0] second_red;
	} pixel_req_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       clipped;
	} pixel_res_t;

	logic clk;
	logic arst_n;

	pbu_in_if  pix_in();
	pbu_out_if pix_out();
	pbu_cfg_if cfg();

	pixel_blend_unit_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	// Shadow copy of the unit's registers, updated on each accepted write.
	logic [7:0]  cur_offset;
	logic [15:0] cur_gain;
	logic [2:0]  cur_mask;

	pixel_req_t pending_reqs[$];
	pixel_res_t expected_pixels[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	logic in_taken;
	logic hold_toggle;
	logic hold_seen;
	int  hold_left;
	int  fail_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up well past the slowest legal run.
	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

	// Clamp a non-negative value to 255; bit 8 of the return flags the clamp.
	function automatic logic [8:0] clamp_high(input longint unsigned v);
		if (v > 64'd255)
			return {1'b1, 8'hFF};
		return {1'b0, v[7:0]};
	endfunction

	// One channel of one request: {clipped, value}.
	function automatic logic [8:0] blend_channel(input logic [2:0] mode, input logic [7:0] a,
			input logic [7:0] b, input logic enabled);
		longint unsigned gain;
		longint unsigned prod;
		gain = cur_gain;
		if (!enabled)
			return {1'b0, a};
		case (mode)
			MODE_ADD: begin
				return clamp_high(longint'(a) + cur_offset);
			end
			MODE_SUB: begin
				if (a < cur_offset)
					return {1'b1, 8'h00};
				return {1'b0, a - cur_offset};
			end
			MODE_SCALE: begin
				return clamp_high((gain * a + 64'd128) >> 8);
			end
			MODE_MULTIPLY: begin
				return clamp_high((gain * a * b + BLEND_RND) / BLEND_DIV);
			end
			MODE_SCREEN: begin
				// Work on the inverted layers; a product past the numerator
				// rounds below zero and pins at black.
				prod = gain * (64'd255 - a) * (64'd255 - b);
				if (prod > SCREEN_NUM)
					return {1'b1, 8'h00};
				return clamp_high((SCREEN_NUM - prod) / BLEND_DIV);
			end
			default: begin
				return {1'b0, a};
			end
		endcase
	endfunction

	function automatic pixel_res_t predict_pixel(input pixel_req_t req);
		pixel_res_t res;
		logic [8:0] blue_r;
		logic [8:0] green_r;
		logic [8:0] red_r;
		logic       blend;
		// Blends ignore the mask; so do the pass-through modes, which have
		// nothing to mask.
		blend = (req.mode > MODE_SCALE);
		blue_r = blend_channel(req.mode, req.first_blue, req.second_blue,
				blend || cur_mask[0]);
		green_r = blend_channel(req.mode, req.first_green, req.second_green,
				blend || cur_mask[1]);
		red_r = blend_channel(req.mode, req.first_red, req.second_red,
				blend || cur_mask[2]);
		res.blue = blue_r[7:0];
		res.green = green_r[7:0];
		res.red = red_r[7:0];
		res.clipped = blue_r[8] | green_r[8] | red_r[8];
		return res;
	endfunction

	// Pixel driver: advance to the next pending request once the current one
	// is taken, or leave valid low at the sender's idle rate.
	always @(negedge clk) begin : pixel_driver
		pixel_req_t req;
		if (!arst_n) begin
			pix_in.valid <= 1'b0;
		end else if (!pix_in.valid || in_taken) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req = pending_reqs.pop_front();
				pix_in.mode <= req.mode;
				pix_in.first_blue <= req.first_blue;
				pix_in.first_green <= req.first_green;
				pix_in.first_red <= req.first_red;
				pix_in.second_blue <= req.second_blue;
				pix_in.second_green <= req.second_green;
				pix_in.second_red <= req.second_red;
				pix_in.valid <= 1'b1;
			end else begin
				pix_in.valid <= 1'b0;
			end
		end
	end

	// Result receiver: a flip of hold_toggle starts a long hold-off; otherwise
	// drop ready at the receiver's idle rate.
	always @(negedge clk) begin : result_receiver
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			pix_out.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pix_out.ready <= 1'b0;
		end else begin
			pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predict on each accepted request, check each accepted result.
	always @(posedge clk) begin : pixel_monitor
		pixel_req_t req;
		pixel_res_t want;
		in_taken <= pix_in.valid && pix_in.ready;
		if (pix_in.valid && pix_in.ready) begin
			req.mode = pix_in.mode;
			req.first_blue = pix_in.first_blue;
			req.first_green = pix_in.first_green;
			req.first_red = pix_in.first_red;
			req.second_blue = pix_in.second_blue;
			req.second_green = pix_in.second_green;
			req.second_red = pix_in.second_red;
			expected_pixels.push_back(predict_pixel(req));
		end
		if (pix_out.valid && pix_out.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("result with no request outstanding: blue %0d green %0d red %0d",
						pix_out.out_blue, pix_out.out_green, pix_out.out_red);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (pix_out.out_blue !== want.blue) begin
					$error("out_blue mismatch: expected %0d, actual %0d",
							want.blue, pix_out.out_blue);
					fail_count++;
				end
				if (pix_out.out_green !== want.green) begin
					$error("out_green mismatch: expected %0d, actual %0d",
							want.green, pix_out.out_green);
					fail_count++;
				end
				if (pix_out.out_red !== want.red) begin
					$error("out_red mismatch: expected %0d, actual %0d",
							want.red, pix_out.out_red);
					fail_count++;
				end
				if (pix_out.clipped !== want.clipped) begin
					$error("clipped mismatch: expected %0d, actual %0d",
							want.clipped, pix_out.clipped);
					fail_count++;
				end
			end
		end
	end

	// Write one register and mirror it into the shadow copy.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg.index <= idx;
		cfg.wdata <= data;
		cfg.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			CFG_OFFSET: cur_offset = data[7:0];
			CFG_SCALE:  cur_gain = data;
			CFG_MASK:   cur_mask = data[2:0];
			default:    ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Load all three registers; fill the unused upper data bits with noise and
	// poke the empty index too, which must leave everything as it was.
	task automatic load_settings(input logic [7:0] offset, input logic [15:0] gain,
			input logic [2:0] mask);
		write_reg(CFG_OFFSET, {8'($urandom), offset});
		write_reg(CFG_SCALE, gain);
		write_reg(CFG_MASK, {13'($urandom), mask});
		write_reg(CFG_NONE, 16'($urandom));
	endtask

	task automatic queue_req(input logic [2:0] mode, input logic [7:0] fb, input logic [7:0] fg,
			input logic [7:0] fr, input logic [7:0] sb, input logic [7:0] sg,
			input logic [7:0] sr);
		pending_reqs.push_back('{mode, fb, fg, fr, sb, sg, sr});
	endtask

	// Hold until every queued request has gone in and every result come out.
	task automatic wait_drained();
		while (pending_reqs.size() > 0 || pix_in.valid || expected_pixels.size() > 0)
			@(posedge clk);
	endtask

	// Channel level with the rails weighted up.
	function automatic logic [7:0] pick_level();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(3))
			0: return 16'($urandom_range(65535));
			1: return 16'($urandom_range(255));
			default: return 16'($urandom_range(1023));
		endcase
	endfunction

	task automatic queue_random_reqs(input int count);
		logic [2:0] mode;
		for (int i = 0; i < count; i++) begin
			// Mostly real modes; a tenth go to the pass-through codes.
			if ($urandom_range(9) == 0)
				mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
			else
				mode = 3'($urandom_range(MODE_ADD, MODE_SCREEN));
			queue_req(mode, pick_level(), pick_level(), pick_level(),
					pick_level(), pick_level(), pick_level());
		end
	endtask

	initial begin : stimulus
		// Drive every input to a known value before the first edge.
		pix_in.valid = 1'b0;
		pix_in.mode = MODE_ADD;
		pix_in.first_blue = 8'h00;
		pix_in.first_green = 8'h00;
		pix_in.first_red = 8'h00;
		pix_in.second_blue = 8'h00;
		pix_in.second_green = 8'h00;
		pix_in.second_red = 8'h00;
		pix_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_OFFSET;
		cfg.wdata = 16'h0000;
		in_taken = 1'b0;
		hold_toggle = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		fail_count = 0;
		send_idle_pct = 30;
		recv_idle_pct = 50;
		// Register values after reset: no offset, unity gain, all channels on.
		cur_offset = 8'd0;
		cur_gain = 16'd256;
		cur_mask = 3'b111;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings first, so identity behavior is visible.
		queue_req(MODE_ADD, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SUB, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		queue_req(MODE_SCALE, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_MULTIPLY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80);
		queue_req(MODE_SCREEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h4D);
		wait_drained();

		// Gain 1.5, green masked off: saturation on both rails, masked
		// channel passing, blends ignoring the mask, unused modes.
		load_settings(8'd100, 16'h0180, 3'b101);
		queue_req(MODE_ADD, 8'd250, 8'd10, 8'd155, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SUB, 8'd99, 8'd200, 8'd100, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SCALE, 8'hFF, 8'hFF, 8'd170, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SCALE, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		queue_req(MODE_MULTIPLY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_req(MODE_MULTIPLY, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		queue_req(MODE_SCREEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SCREEN, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_UNUSED_LO, 8'd12, 8'd34, 8'd56, 8'hFF, 8'hFF, 8'hFF);
		queue_req(MODE_UNUSED_MID, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
		queue_req(MODE_UNUSED_HI, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
		wait_drained();

		// Top offset and gain with every channel masked.
		load_settings(8'd255, 16'hFFFF, 3'b000);
		queue_req(MODE_ADD, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SUB, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SCALE, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_MULTIPLY, 8'd1, 8'd2, 8'd3, 8'd1, 8'd1, 8'd1);
		queue_req(MODE_SCREEN, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80);
		wait_drained();

		// Same offset, channels back on: add and subtract hit both rails.
		load_settings(8'd255, 16'h0000, 3'b111);
		queue_req(MODE_ADD, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SUB, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_req(MODE_SCREEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		wait_drained();

		// Random phases: extremes first, then random settings. Idle pattern
		// changes every four phases; the first quiet phase also gets the
		// long hold-off so the pipe fills and backs up into pix_in.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph < 4) begin
				send_idle_pct = 30;
				recv_idle_pct = 50;
			end else if (ph < 8) begin
				send_idle_pct = 50;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (ph)
				0: load_settings(8'd255, 16'h0000, 3'b000);
				1: load_settings(8'd0, 16'hFFFF, 3'b111);
				2: load_settings(8'd1, 16'h0100, 3'b010);
				default: load_settings(8'($urandom_range(255)), pick_gain(),
						3'($urandom_range(7)));
			endcase
			if (ph == 8)
				hold_toggle = ~hold_toggle;
			queue_random_reqs(PHASE_REQS);
			wait_drained();
		end

		// Let any stray result show before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_pixels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
